// ===== rtl/der_tlv_header_parser_macros.svh =====
// Assertion macros shared by the DER header parser RTL.
// Included by the files that carry concurrent assertions; depends on nothing.
`ifndef DER_TLV_HEADER_PARSER_MACROS_SVH
`define DER_TLV_HEADER_PARSER_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define DTHP_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("DER header parser check failed");

// Implication into the following cycle.
`define DTHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("DER header parser check failed");

`endif

// ===== rtl/dthp_pkg.sv =====
// Types and codes for the DER TLV header parser.
// Depends on nothing; used by dthp_result_if, dthp_core, dthp_out_stage and the top module.
`default_nettype none

package dthp_pkg;

  typedef enum logic [1:0] {
    PhTag      = 2'd0,
    PhLenFirst = 2'd1,
    PhLenLong  = 2'd2,
    PhPayload  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    RoleTag  = 2'd0,
    RoleLen  = 2'd1,
    RolePay  = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    ErrOk      = 2'd0,
    ErrIndef   = 2'd1,
    ErrTooMany = 2'd2
  } err_e;

  localparam int unsigned CfgWidth     = 3;
  localparam int unsigned LenOutWidth  = 32;
  localparam logic [CfgWidth-1:0] CfgReset = 3'd4;
  localparam int unsigned LongFormBit  = 7;

  typedef struct packed {
    logic [7:0]             byte_out;
    role_e                  byte_role;
    logic [7:0]             element_tag;
    logic [LenOutWidth-1:0] payload_length;
    logic                   header_done;
    logic                   element_end;
    err_e                   error_code;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/dthp_if.sv =====
// Valid/ready channel interfaces for the DER header parser: byte input and result output.
// Depends on dthp_pkg for the result type.
`default_nettype none

interface dthp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface dthp_result_if;
  logic              valid;
  logic              ready;
  dthp_pkg::result_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/dthp_in_stage.sv =====
// Input register of the DER header parser: holds one byte until the core takes it.
// Depends on the dthp_byte_if interface.
`default_nettype none

module dthp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  dthp_byte_if.sink       byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;
  logic       accept;

  assign byte_i.ready = !valid_q || take_i;
  assign accept       = byte_i.valid && byte_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_i.data_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o  = byte_q;

endmodule

`default_nettype wire

// ===== rtl/dthp_core.sv =====
// Parser state and per-byte decode of the DER header parser.
// Depends on dthp_pkg and the assertion macro header.
`default_nettype none
`include "der_tlv_header_parser_macros.svh"

module dthp_core #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dthp_pkg::CfgWidth-1:0] cfg_wdata_i,
  input  wire logic                          step_i,
  input  wire logic [7:0]                    byte_i,
  output dthp_pkg::result_t                  res_o
);
  import dthp_pkg::*;

  localparam int unsigned OctetCap = LENGTH_BITS / 8;
  localparam logic [CfgWidth-1:0] OctetCapW = CfgWidth'(OctetCap);

  logic [CfgWidth-1:0]    max_oct_q;
  phase_e                 phase_q, phase_d;
  logic [7:0]             tag_q, tag_d;
  logic [LENGTH_BITS-1:0] accum_q, accum_d;
  logic [CfgWidth-1:0]    oct_left_q, oct_left_d;
  logic [LENGTH_BITS-1:0] pay_left_q, pay_left_d;

  logic [CfgWidth-1:0]    limit;
  logic [6:0]             oct_count;
  logic [LENGTH_BITS+7:0] shifted;
  logic [LENGTH_BITS-1:0] hdr_len;
  logic                   hdr_fin;
  logic [CfgWidth-1:0]    oct_dec;
  logic [LENGTH_BITS-1:0] pay_dec;

  assign limit     = (max_oct_q > OctetCapW) ? OctetCapW : max_oct_q;
  assign oct_count = byte_i[6:0];
  assign shifted   = {accum_q, byte_i};
  assign oct_dec   = (oct_left_q != '0) ? oct_left_q - 1'b1 : oct_left_q;
  assign pay_dec   = (pay_left_q != '0) ? pay_left_q - 1'b1 : pay_left_q;

  // Next state and header completion.
  always_comb begin
    phase_d    = phase_q;
    tag_d      = tag_q;
    accum_d    = accum_q;
    oct_left_d = oct_left_q;
    pay_left_d = pay_left_q;
    hdr_fin    = 1'b0;
    hdr_len    = '0;
    case (phase_q)
      PhTag: begin
        tag_d      = byte_i;
        accum_d    = '0;
        oct_left_d = '0;
        phase_d    = PhLenFirst;
      end
      PhLenFirst: begin
        if (!byte_i[LongFormBit]) begin
          hdr_fin = 1'b1;
          hdr_len = LENGTH_BITS'(byte_i);
        end else if (oct_count == '0) begin
          phase_d = PhTag;
        end else if (oct_count > 7'(limit)) begin
          phase_d = PhTag;
        end else begin
          accum_d    = '0;
          oct_left_d = oct_count[CfgWidth-1:0];
          phase_d    = PhLenLong;
        end
      end
      PhLenLong: begin
        accum_d    = shifted[LENGTH_BITS-1:0];
        oct_left_d = oct_dec;
        if (oct_dec == '0) begin
          hdr_fin = 1'b1;
          hdr_len = shifted[LENGTH_BITS-1:0];
        end
      end
      PhPayload: begin
        pay_left_d = pay_dec;
        if (pay_dec == '0) begin
          phase_d = PhTag;
        end
      end
      default: begin
        phase_d = PhTag;
      end
    endcase
    if (hdr_fin) begin
      pay_left_d = hdr_len;
      phase_d    = (hdr_len == '0) ? PhTag : PhPayload;
    end
  end

  // Result fields for the byte in hand.
  always_comb begin
    res_o                = '0;
    res_o.byte_out       = byte_i;
    res_o.byte_role      = RoleTag;
    res_o.element_tag    = tag_q;
    res_o.error_code     = ErrOk;
    res_o.header_done    = hdr_fin;
    res_o.payload_length = hdr_fin ? LenOutWidth'(hdr_len) : '0;
    res_o.element_end    = hdr_fin && (hdr_len == '0);
    case (phase_q)
      PhTag: begin
        res_o.element_tag = byte_i;
      end
      PhLenFirst: begin
        res_o.byte_role = RoleLen;
        if (byte_i[LongFormBit]) begin
          if (oct_count == '0) begin
            res_o.error_code = ErrIndef;
          end else if (oct_count > 7'(limit)) begin
            res_o.error_code = ErrTooMany;
          end
        end
      end
      PhLenLong: begin
        res_o.byte_role = RoleLen;
      end
      PhPayload: begin
        res_o.byte_role   = RolePay;
        res_o.element_end = (pay_dec == '0);
      end
      default: begin
        res_o.byte_role = RoleTag;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_oct_q  <= CfgReset;
      phase_q    <= PhTag;
      tag_q      <= '0;
      accum_q    <= '0;
      oct_left_q <= '0;
      pay_left_q <= '0;
    end else begin
      if (cfg_we_i) begin
        max_oct_q <= cfg_wdata_i;
      end
      if (step_i) begin
        phase_q    <= phase_d;
        tag_q      <= tag_d;
        accum_q    <= accum_d;
        oct_left_q <= oct_left_d;
        pay_left_q <= pay_left_d;
      end
    end
  end

  // A rejected length field always sends the parser back to a tag byte.
  `DTHP_ASSERT_NEXT(a_err_resync, clk_i, rst_ni, step_i && (res_o.error_code != ErrOk), phase_q == PhTag)
  // A header that completes with a nonzero length opens a payload.
  `DTHP_ASSERT_NEXT(a_hdr_payload, clk_i, rst_ni, step_i && res_o.header_done && !res_o.element_end, (phase_q == PhPayload) && (pay_left_q != '0))
  // The completing byte and any error both belong to the length field.
  `DTHP_ASSERT_NOW(a_hdr_role, clk_i, rst_ni, res_o.header_done || (res_o.error_code != ErrOk), res_o.byte_role == RoleLen)
  // Once in a payload, the remaining count is never zero.
  `DTHP_ASSERT_NOW(a_pay_nonzero, clk_i, rst_ni, phase_q == PhPayload, pay_left_q != '0)

endmodule

`default_nettype wire

// ===== rtl/dthp_out_stage.sv =====
// Result register of the DER header parser, driving the result channel.
// Depends on dthp_pkg and the dthp_result_if interface.
`default_nettype none

module dthp_out_stage (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          load_i,
  input  dthp_pkg::result_t  res_i,
  output logic               free_o,
  dthp_result_if.source      result_o
);
  import dthp_pkg::*;

  logic    valid_q;
  logic    valid_d;
  result_t res_q;

  assign free_o = !valid_q || result_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (result_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign result_o.valid   = valid_q;
  assign result_o.payload = res_q;

endmodule

`default_nettype wire

// ===== rtl/der_tlv_header_parser.sv =====
// Channel     | Dir | Contents
// ------------+-----+------------------------------------------------------
// byte_i      | in  | data_byte, one byte of the DER element stream
// result_o    | out | byte_out, byte_role, element_tag, payload_length,
//             |     | header_done, element_end, error_code
// cfg_we_i    | in  | max_length_octets write, data on cfg_wdata_i
//
// One byte per clock is sustained while result_o is ready; a byte's result is
// presented after it passes through the input register and the result register.
// The parser state update on each byte is the single loop that sets this rate.
// Reset returns the parser to expecting a tag byte with max_length_octets at 4.
// A stalled result channel holds the result register and then the input register.
`default_nettype none

module der_tlv_header_parser #(
  parameter int unsigned LENGTH_BITS = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [dthp_pkg::CfgWidth-1:0] cfg_wdata_i,
  dthp_byte_if.sink                          byte_i,
  dthp_result_if.source                      result_o
);
  import dthp_pkg::*;

  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       out_free;
  logic       step;
  result_t    res;

  assign step = stage_valid && out_free;

  dthp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .byte_i  (byte_i),
    .take_i  (step),
    .valid_o (stage_valid),
    .byte_o  (stage_byte)
  );

  dthp_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .byte_i      (stage_byte),
    .res_o       (res)
  );

  dthp_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (step),
    .res_i    (res),
    .free_o   (out_free),
    .result_o (result_o)
  );

endmodule

`default_nettype wire
